/* rtl/core/fvl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvl_pkg
// Shared types and codes of the FAT volume layout calculator: request and
// result beats, configuration register indexes, status and partition codes.
// ----------------------------------------------------------------------------
package fvl_pkg;

    // configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FAT16_ALIGN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FAT32_ALIGN = 1'b1;

    localparam logic [CFG_W-1:0] FAT16_ALIGN_RST = 17'd128;
    localparam logic [CFG_W-1:0] FAT32_ALIGN_RST = 17'd8192;
    localparam logic [CFG_W-1:0] ALIGN_MAX       = 17'd65536;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TOO_SMALL = 2'd1;
    localparam logic [1:0] STAT_BAD_COUNT = 2'd2;
    localparam logic [1:0] STAT_BAD_CYL   = 2'd3;

    // mbr partition type bytes
    localparam logic [7:0] KIND_FAT12       = 8'h01;
    localparam logic [7:0] KIND_FAT16_SMALL = 8'h04;
    localparam logic [7:0] KIND_FAT16_BIG   = 8'h06;
    localparam logic [7:0] KIND_FAT32_CHS   = 8'h0B;
    localparam logic [7:0] KIND_FAT32_LBA   = 8'h0C;

    // request beat
    typedef struct packed {
        logic [31:0] card_blocks;
        logic        card_is_sdhc;
    } fvl_in_t;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  cluster_sectors;
        logic [7:0]  head_count;
        logic [5:0]  track_sectors;
        logic [31:0] partition_start;
        logic [15:0] reserved_count;
        logic [31:0] fat_sectors;
        logic [31:0] data_begin;
        logic [31:0] partition_length;
        logic [7:0]  partition_kind;
        logic [23:0] chs_first;
        logic [23:0] chs_last;
    } fvl_out_t;

endpackage

/* rtl/core/fat_volume_layout_calculator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_volume_layout_calculator_top
// Computes the FAT16 or FAT32 volume layout of an SD card from its size.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the result comes
// back as one beat with done high for a single cycle and cannot be held off,
// so the receiver must capture it in that cycle. The result ports keep their
// value until the next result. A radix-2 divider finds the search bound,
// the data start search then runs up to 33 binary steps on one shared
// multiply/add datapath, and the CHS addresses take up to four more passes
// through the same divider. A too-small card finishes without the divider.
// Busy stays high for the whole request and falls in the cycle done is shown.
// Alignment registers are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while no request is in flight, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module fat_volume_layout_calculator_top
    import fvl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fvl_in_t              item,
    output logic                 busy,
    output logic                 done,
    output fvl_out_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_NC     = 4'd5;
    localparam logic [3:0] S_FS     = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_EVAL   = 4'd8;
    localparam logic [3:0] S_LAYOUT = 4'd9;
    localparam logic [3:0] S_KIND   = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_DIVEND = 4'd12;
    localparam logic [3:0] S_FINISH = 4'd13;

    // divider jobs
    localparam logic [1:0] OP_BOUND = 2'd0;
    localparam logic [1:0] OP_CYL   = 2'd1;
    localparam logic [1:0] OP_HEAD  = 2'd2;

    localparam logic [31:0] CYL_MAX        = 32'd1023;
    localparam logic [32:0] CHS_LIMIT      = 33'd16450560;
    localparam logic [31:0] FAT12_LIMIT    = 32'd32680;
    localparam logic [31:0] FAT16_LIMIT    = 32'd65536;
    localparam logic [30:0] FAT16_MIN_CLU  = 31'd4085;
    localparam logic [30:0] FAT16_MAX_CLU  = 31'd65525;
    localparam logic [23:0] CHS_SATURATED  = {10'd1023, 8'd254, 6'd63};

    // control state
    logic [3:0]       state_reg, state_next;
    logic             done_reg, done_next;
    logic [CFG_W-1:0] a16_cfg_reg, a16_cfg_next;
    logic [CFG_W-1:0] a32_cfg_reg, a32_cfg_next;

    // datapath registers
    fvl_out_t    res_reg, res_next;
    logic [31:0] card_reg, card_next;
    logic        f32_reg, f32_next;
    logic [16:0] a_reg, a_next;
    logic [2:0]  sh_reg, sh_next;
    logic [7:0]  heads_reg, heads_next;
    logic [5:0]  spt_reg, spt_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] k_reg, k_next;
    logic        final_reg, final_next;
    logic [31:0] prod_reg, prod_next;
    logic [33:0] d_reg, d_next;
    logic        past_reg, past_next;
    logic [30:0] nc_reg, nc_next;
    logic [24:0] fs_reg, fs_next;
    logic [31:0] rel_reg, rel_next;
    logic [15:0] rsv_reg, rsv_next;
    logic [31:0] psize_reg, psize_next;
    logic [7:0]  kind_reg, kind_next;
    logic [9:0]  cyl_reg, cyl_next;
    logic [23:0] chs_first_reg, chs_first_next;
    logic [23:0] chs_last_reg, chs_last_next;
    logic        end_reg, end_next;
    logic [1:0]  status_reg, status_next;
    logic [16:0] div_rem_reg, div_rem_next;
    logic [31:0] div_quo_reg, div_quo_next;
    logic [16:0] div_den_reg, div_den_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [1:0]  div_op_reg, div_op_next;

    // combinational helpers
    logic [16:0] a16_clamp, a32_clamp;
    logic [21:0] mb;
    logic [31:0] mid;
    logic [17:0] div_part, div_sub;
    logic        div_ge;
    logic [13:0] hs;
    logic [48:0] prod_full;
    logic [31:0] diff;
    logic [25:0] two_fs;
    logic [26:0] r_val;
    logic [33:0] rel16, rsv32;
    logic [39:0] ncs, psize16, psize32;
    logic [32:0] chs_sum;
    logic [31:0] lbn_end;
    logic [23:0] chs_packed;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // alignment clamp: zero reads as one, above the maximum reads as maximum
    always_comb
    begin
        priority if (a16_cfg_reg == '0)
            a16_clamp = 17'd1;
        else if (a16_cfg_reg > ALIGN_MAX)
            a16_clamp = ALIGN_MAX;
        else
            a16_clamp = a16_cfg_reg;
        priority if (a32_cfg_reg == '0)
            a32_clamp = 17'd1;
        else if (a32_cfg_reg > ALIGN_MAX)
            a32_clamp = ALIGN_MAX;
        else
            a32_clamp = a32_cfg_reg;
    end

    // shared arithmetic
    assign mb        = 22'((33'(card_reg) + 33'd2047) >> 11);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign div_part  = {div_rem_reg, div_quo_reg[31]};
    assign div_ge    = (div_part >= {1'b0, div_den_reg});
    assign div_sub   = div_part - {1'b0, div_den_reg};
    assign hs        = 14'({6'd0, heads_reg} * {8'd0, spt_reg});
    // k never exceeds card / a, so the product stays within 32 bits
    assign prod_full = {17'd0, k_reg} * {32'd0, a_reg};
    assign diff      = card_reg - d_reg[31:0];
    assign two_fs    = {fs_reg, 1'b0};
    assign r_val     = 27'(a_reg) + (f32_reg ? 27'd9 : 27'd33) + 27'(two_fs);
    assign rel16     = d_reg - 34'(two_fs) - 34'd33;
    assign rsv32     = d_reg - 34'(a_reg) - 34'(two_fs);
    assign ncs       = 40'(nc_reg) << sh_reg;
    assign psize16   = ncs + 40'(two_fs) + 40'd33;
    assign psize32   = ncs + 40'(d_reg) - 40'(a_reg);
    assign chs_sum   = 33'(rel_reg) + 33'(psize_reg);
    assign lbn_end   = rel_reg + psize_reg - 32'd1;
    assign chs_packed = {cyl_reg, div_quo_reg[7:0], div_rem_reg[5:0] + 6'd1};

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        a16_cfg_next   = a16_cfg_reg;
        a32_cfg_next   = a32_cfg_reg;
        res_next       = res_reg;
        card_next      = card_reg;
        f32_next       = f32_reg;
        a_next         = a_reg;
        sh_next        = sh_reg;
        heads_next     = heads_reg;
        spt_next       = spt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        final_next     = final_reg;
        prod_next      = prod_reg;
        d_next         = d_reg;
        past_next      = past_reg;
        nc_next        = nc_reg;
        fs_next        = fs_reg;
        rel_next       = rel_reg;
        rsv_next       = rsv_reg;
        psize_next     = psize_reg;
        kind_next      = kind_reg;
        cyl_next       = cyl_reg;
        chs_first_next = chs_first_reg;
        chs_last_next  = chs_last_reg;
        end_next       = end_reg;
        status_next    = status_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        div_op_next    = div_op_reg;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FAT16_ALIGN: a16_cfg_next = cfg_data;
                REG_FAT32_ALIGN: a32_cfg_next = cfg_data;
                default:         a16_cfg_next = a16_cfg_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    card_next  = item.card_blocks;
                    f32_next   = item.card_is_sdhc;
                    a_next     = item.card_is_sdhc ? a32_clamp : a16_clamp;
                    final_next = 1'b0;
                    state_next = S_SETUP;
                end
            end

            // capacity class, geometry, then divide for the search bound unless the card is too small
            S_SETUP:
            begin
                priority if (mb <= 22'd16)    sh_next = 3'd1;
                else if (mb <= 22'd32)        sh_next = 3'd2;
                else if (mb <= 22'd64)        sh_next = 3'd3;
                else if (mb <= 22'd128)       sh_next = 3'd4;
                else if (mb <= 22'd1024)      sh_next = 3'd5;
                else if (mb <= 22'd32768)     sh_next = 3'd6;
                else                          sh_next = 3'd7;
                spt_next = (mb <= 22'd256) ? 6'd32 : 6'd63;
                priority if (mb <= 22'd16)    heads_next = 8'd2;
                else if (mb <= 22'd32)        heads_next = 8'd4;
                else if (mb <= 22'd128)       heads_next = 8'd8;
                else if (mb <= 22'd504)       heads_next = 8'd16;
                else if (mb <= 22'd1008)      heads_next = 8'd32;
                else if (mb <= 22'd2016)      heads_next = 8'd64;
                else if (mb <= 22'd4032)      heads_next = 8'd128;
                else                          heads_next = 8'd255;
                if (mb <= 22'd6)
                begin
                    status_next = STAT_TOO_SMALL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    div_quo_next = card_reg;
                    div_rem_next = '0;
                    div_den_next = a_reg;
                    div_cnt_next = 5'd31;
                    div_op_next  = OP_BOUND;
                    state_next   = S_DIV;
                end
            end

            // pick the next probe of the binary search
            S_CHECK:
            begin
                if (lo_reg < hi_reg)
                    k_next = mid;
                else
                begin
                    k_next     = lo_reg;
                    final_next = 1'b1;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = prod_full[31:0];
                state_next = S_ADD;
            end

            // data start = (k + 2) * align
            S_ADD:
            begin
                d_next     = 34'(prod_reg) + 34'({a_reg, 1'b0});
                state_next = S_NC;
            end

            // cluster count of the remaining blocks
            S_NC:
            begin
                past_next  = (d_reg > 34'(card_reg));
                nc_next    = (d_reg > 34'(card_reg)) ? '0 : 31'(diff >> sh_reg);
                state_next = S_FS;
            end

            // fat size rounded up
            S_FS:
            begin
                if (past_reg)
                    fs_next = '0;
                else if (f32_reg)
                    fs_next = 25'((32'(nc_reg) + 32'd129) >> 7);
                else
                    fs_next = 25'((32'(nc_reg) + 32'd257) >> 8);
                state_next = S_CMP;
            end

            // room check narrows the search interval
            S_CMP:
            begin
                if (final_reg)
                    state_next = S_EVAL;
                else
                begin
                    if (past_reg || (d_reg >= 34'(r_val)))
                        hi_next = k_reg;
                    else
                        lo_next = k_reg + 32'd1;
                    state_next = S_CHECK;
                end
            end

            S_EVAL:
            begin
                if (past_reg ||
                    (f32_reg ? (nc_reg < FAT16_MAX_CLU)
                             : ((nc_reg < FAT16_MIN_CLU) || (nc_reg >= FAT16_MAX_CLU))))
                begin
                    status_next = STAT_BAD_COUNT;
                    state_next  = S_FINISH;
                end
                else
                    state_next = S_LAYOUT;
            end

            // partition start, reserved area and size
            S_LAYOUT:
            begin
                status_next = STAT_OK;
                if (f32_reg)
                begin
                    rel_next   = 32'(a_reg);
                    rsv_next   = (rsv32 > 34'd65535) ? 16'hFFFF : rsv32[15:0];
                    psize_next = psize32[31:0];
                end
                else
                begin
                    rel_next   = rel16[31:0];
                    rsv_next   = 16'd1;
                    psize_next = psize16[31:0];
                end
                state_next = S_KIND;
            end

            // partition type, then divide start block by heads * sectors
            S_KIND:
            begin
                if (f32_reg)
                    kind_next = (chs_sum <= CHS_LIMIT) ? KIND_FAT32_CHS : KIND_FAT32_LBA;
                else if (psize_reg < FAT12_LIMIT)
                    kind_next = KIND_FAT12;
                else if (psize_reg < FAT16_LIMIT)
                    kind_next = KIND_FAT16_SMALL;
                else
                    kind_next = KIND_FAT16_BIG;
                end_next     = 1'b0;
                div_quo_next = rel_reg;
                div_rem_next = '0;
                div_den_next = 17'(hs);
                div_cnt_next = 5'd31;
                div_op_next  = OP_CYL;
                state_next   = S_DIV;
            end

            // restoring divider, one quotient bit a cycle
            S_DIV:
            begin
                div_rem_next = div_ge ? div_sub[16:0] : div_part[16:0];
                div_quo_next = {div_quo_reg[30:0], div_ge};
                if (div_cnt_reg == '0)
                    state_next = S_DIVEND;
                else
                    div_cnt_next = div_cnt_reg - 5'd1;
            end

            S_DIVEND:
            begin
                unique case (div_op_reg)
                    OP_BOUND:
                    begin
                        lo_next    = '0;
                        hi_next    = div_quo_reg;
                        state_next = S_CHECK;
                    end
                    OP_CYL:
                    begin
                        if (div_quo_reg > CYL_MAX)
                        begin
                            if (end_reg)
                                chs_last_next = CHS_SATURATED;
                            else
                                status_next = STAT_BAD_CYL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cyl_next     = div_quo_reg[9:0];
                            div_quo_next = 32'(div_rem_reg);
                            div_rem_next = '0;
                            div_den_next = 17'(spt_reg);
                            div_cnt_next = 5'd31;
                            div_op_next  = OP_HEAD;
                            state_next   = S_DIV;
                        end
                    end
                    OP_HEAD:
                    begin
                        if (end_reg)
                        begin
                            chs_last_next = chs_packed;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            chs_first_next = chs_packed;
                            end_next       = 1'b1;
                            div_quo_next   = lbn_end;
                            div_rem_next   = '0;
                            div_den_next   = 17'(hs);
                            div_cnt_next   = 5'd31;
                            div_op_next    = OP_CYL;
                            state_next     = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // assemble the result beat by status
            S_FINISH:
            begin
                res_next        = '0;
                res_next.status = status_reg;
                if (status_reg != STAT_TOO_SMALL)
                begin
                    res_next.cluster_sectors = 8'd1 << sh_reg;
                    res_next.head_count      = heads_reg;
                    res_next.track_sectors   = spt_reg;
                end
                if ((status_reg == STAT_OK) || (status_reg == STAT_BAD_CYL))
                begin
                    res_next.partition_start  = rel_reg;
                    res_next.reserved_count   = rsv_reg;
                    res_next.fat_sectors      = 32'(fs_reg);
                    res_next.data_begin       = d_reg[31:0];
                    res_next.partition_length = psize_reg;
                    res_next.partition_kind   = kind_reg;
                end
                if (status_reg == STAT_OK)
                begin
                    res_next.chs_first = chs_first_reg;
                    res_next.chs_last  = chs_last_reg;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            a16_cfg_reg <= FAT16_ALIGN_RST;
            a32_cfg_reg <= FAT32_ALIGN_RST;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            a16_cfg_reg <= a16_cfg_next;
            a32_cfg_reg <= a32_cfg_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        card_reg      <= card_next;
        f32_reg       <= f32_next;
        a_reg         <= a_next;
        sh_reg        <= sh_next;
        heads_reg     <= heads_next;
        spt_reg       <= spt_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        k_reg         <= k_next;
        final_reg     <= final_next;
        prod_reg      <= prod_next;
        d_reg         <= d_next;
        past_reg      <= past_next;
        nc_reg        <= nc_next;
        fs_reg        <= fs_next;
        rel_reg       <= rel_next;
        rsv_reg       <= rsv_next;
        psize_reg     <= psize_next;
        kind_reg      <= kind_next;
        cyl_reg       <= cyl_next;
        chs_first_reg <= chs_first_next;
        chs_last_reg  <= chs_last_next;
        end_reg       <= end_next;
        status_reg    <= status_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_den_reg   <= div_den_next;
        div_cnt_reg   <= div_cnt_next;
        div_op_reg    <= div_op_next;
    end

endmodule

/* rtl/core/fvl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvl_checker
// Port-level checks of the FAT volume layout calculator, bound to its top.
// ----------------------------------------------------------------------------
module fvl_checker
    import fvl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input fvl_out_t result
);

    // a request keeps the block busy after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // the result beat is shown when the block has gone idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // one beat per request, never two in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // too small card gives an empty layout
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_TOO_SMALL)) |->
            ((result.cluster_sectors == '0) && (result.partition_kind == '0)))
        else $error("too small card with layout fields set");

    // good layout carries real geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_OK)) |->
            ((result.cluster_sectors != '0) &&
             ((result.track_sectors == 6'd32) || (result.track_sectors == 6'd63))))
        else $error("good layout with bad geometry");

endmodule

bind fat_volume_layout_calculator_top fvl_checker u_fvl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
